/* hw/rtl/sha_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    // input item kinds (s_tuser)
    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam int S_TDATA_W = 8;
    localparam int DIGEST_W  = 32;
    localparam int INDEX_W   = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - DIGEST_W - INDEX_W;

    localparam logic [INDEX_W-1:0] DIGEST_LAST = 3'd7;

    // default depth of the word queue between front and core (one block)
    localparam int SHA_Q_DEPTH = 16;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [7:0][31:0] SHA_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // one queued message word; final_blk marks the last word of the last block
    typedef struct packed {
        logic [31:0] word;
        logic        final_blk;
    } qitem_t;

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;
            6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;
            6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;
            6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;
            6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;
            6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;
            6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;
            6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;
            6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;
            6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;
            6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;
            6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;
            6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;
            6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;
            6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;
            6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;
            6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;
            6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;
            6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;
            6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;
            6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;
            6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;
            6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;
            6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;
            6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

/* hw/rtl/sha_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_front
// Takes byte items, packs them into big-endian words and, on finish,
// generates the padding and length words of the closing block(s).
// ----------------------------------------------------------------------------
module sha_front
    import sha_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] kind
    output logic                 push_valid,
    input  logic                 push_ready,
    output qitem_t               push_item
);

    typedef enum logic {F_ACCEPT, F_PAD} fstate_t;

    fstate_t     state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  pidx_reg, pidx_next;
    logic        first_reg, first_next;
    logic        lenblk_reg, lenblk_next;

    logic        accept;
    logic [31:0] pad_word;

    assign s_tready = (state_reg == F_ACCEPT) && push_ready;
    assign accept   = s_tvalid && s_tready;

    // bytes already held in acc_reg, then 0x80, then zeros
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    pad_word = {PAD_BYTE, 24'd0};
            2'd1:    pad_word = {acc_reg[7:0], PAD_BYTE, 16'd0};
            2'd2:    pad_word = {acc_reg[15:0], PAD_BYTE, 8'd0};
            2'd3:    pad_word = {acc_reg[23:0], PAD_BYTE};
            default: pad_word = {PAD_BYTE, 24'd0};
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        bits_next   = bits_reg;
        acc_next    = acc_reg;
        pidx_next   = pidx_reg;
        first_next  = first_reg;
        lenblk_next = lenblk_reg;
        push_valid  = 1'b0;
        push_item   = '{word: {acc_reg[23:0], s_tdata}, final_blk: 1'b0};

        case (state_reg)
            F_ACCEPT:
            begin
                if (accept)
                begin
                    if (s_tuser == KIND_ABSORB)
                    begin
                        acc_next  = {acc_reg[23:0], s_tdata};
                        bits_next = bits_reg + 64'd8;
                        fill_next = fill_reg + 6'd1;
                        push_valid = (fill_reg[1:0] == 2'd3);
                    end
                    else
                    begin
                        acc_next    = pad_word;
                        pidx_next   = fill_reg[5:2];
                        first_next  = 1'b1;
                        // length fits behind the pad word only below word 14
                        lenblk_next = (fill_reg[5:2] < 4'd14);
                        fill_next   = 6'd0;
                        state_next  = F_PAD;
                    end
                end
            end
            F_PAD:
            begin
                push_valid = 1'b1;
                if (first_reg)
                    push_item.word = acc_reg;
                else if (lenblk_reg && pidx_reg == 4'd14)
                    push_item.word = bits_reg[63:32];
                else if (lenblk_reg && pidx_reg == 4'd15)
                    push_item.word = bits_reg[31:0];
                else
                    push_item.word = 32'd0;
                push_item.final_blk = lenblk_reg && (pidx_reg == 4'd15);

                if (push_ready)
                begin
                    first_next = 1'b0;
                    pidx_next  = pidx_reg + 4'd1;
                    if (pidx_reg == 4'd15)
                        lenblk_next = 1'b1;
                    if (push_item.final_blk)
                    begin
                        bits_next  = 64'd0;
                        state_next = F_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = F_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_ACCEPT;
            fill_reg   <= 6'd0;
            bits_reg   <= 64'd0;
            pidx_reg   <= 4'd0;
            first_reg  <= 1'b0;
            lenblk_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            bits_reg   <= bits_next;
            pidx_reg   <= pidx_next;
            first_reg  <= first_next;
            lenblk_reg <= lenblk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

/* hw/rtl/sha_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_fifo
// Word queue between the byte front end and the compression core.
// ----------------------------------------------------------------------------
module sha_fifo
    import sha_pkg::*;
#(
    parameter int DEPTH = SHA_Q_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_valid,
    output logic   push_ready,
    input  qitem_t push_item,
    output logic   pop_valid,
    input  logic   pop_ready,
    output qitem_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qitem_t          mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* hw/rtl/sha_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_core
// Compression engine: loads 16 words, runs 64 rounds on one round unit,
// folds into the chaining words and streams out the digest.
// ----------------------------------------------------------------------------
module sha_core
    import sha_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  qitem_t               q_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                 m_tlast    // last
);

    typedef enum logic [1:0] {C_LOAD, C_ROUND, C_ADD, C_OUT} cstate_t;

    localparam logic [5:0] LOAD_LAST  = 6'd15;
    localparam logic [5:0] ROUND_LAST = 6'd63;

    cstate_t           state_reg, state_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [15:0][31:0] w_reg, w_next;
    logic [7:0][31:0]  s_reg, s_next;
    logic [7:0][31:0]  h_reg, h_next;
    logic              final_reg, final_next;
    logic              valid_reg, valid_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [31:0]       word_reg, word_next;

    logic [31:0] t1, t2, w_new;

    assign t1 = s_reg[7] + bsig1(s_reg[4]) + ch(s_reg[4], s_reg[5], s_reg[6])
              + round_k(cnt_reg) + w_reg[0];
    assign t2 = bsig0(s_reg[0]) + maj(s_reg[0], s_reg[1], s_reg[2]);
    // schedule word 16 rounds ahead, from registered taps only
    assign w_new = ssig1(w_reg[14]) + w_reg[9] + ssig0(w_reg[1]) + w_reg[0];

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, idx_reg, word_reg};
    assign m_tlast  = (idx_reg == DIGEST_LAST);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        w_next     = w_reg;
        s_next     = s_reg;
        h_next     = h_reg;
        final_next = final_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        word_next  = word_reg;
        q_pop      = 1'b0;

        case (state_reg)
            C_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop  = 1'b1;
                    w_next = {q_item.word, w_reg[15:1]};
                    if (cnt_reg == LOAD_LAST)
                    begin
                        final_next = q_item.final_blk;
                        s_next     = h_reg;
                        cnt_next   = 6'd0;
                        state_next = C_ROUND;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            C_ROUND:
            begin
                s_next = {s_reg[6], s_reg[5], s_reg[4], s_reg[3] + t1,
                          s_reg[2], s_reg[1], s_reg[0], t1 + t2};
                w_next = {w_new, w_reg[15:1]};
                if (cnt_reg == ROUND_LAST)
                begin
                    cnt_next   = 6'd0;
                    state_next = C_ADD;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            C_ADD:
            begin
                for (int i = 0; i < 8; i++)
                    h_next[i] = h_reg[i] + s_reg[i];
                if (final_reg)
                begin
                    word_next  = h_reg[0] + s_reg[0];
                    idx_next   = '0;
                    valid_next = 1'b1;
                    state_next = C_OUT;
                end
                else
                begin
                    state_next = C_LOAD;
                end
            end
            C_OUT:
            begin
                if (m_tready)
                begin
                    if (idx_reg == DIGEST_LAST)
                    begin
                        valid_next = 1'b0;
                        h_next     = SHA_INIT;
                        state_next = C_LOAD;
                    end
                    else
                    begin
                        idx_next  = idx_reg + 3'd1;
                        word_next = h_reg[idx_reg + 3'd1];
                    end
                end
            end
            default:
            begin
                state_next = C_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_LOAD;
            cnt_reg   <= 6'd0;
            h_reg     <= SHA_INIT;
            final_reg <= 1'b0;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            h_reg     <= h_next;
            final_reg <= final_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        s_reg    <= s_next;
        word_reg <= word_next;
    end

endmodule

/* hw/rtl/sha256_byte_stream_hasher.sv */
`timescale 1ns / 1ps
// Absorb items: one byte per cycle while the word queue (Q_DEPTH words) has room.
// Each 64-byte block passes through the core's load, round and add steps on the shared
// round unit, which takes no new block until it is through with the last one.
// Finish: s_tready drops while 16 - fill/4 pad/length words (32 - fill/4 at 56+ bytes)
// are queued. The 8 digest words then go out one per cycle while m_tready is high.
// Reset (rst_n low, asynchronous): queue empty, chaining words at initial values.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream: front end, word queue and compression core.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
    import sha_pkg::*;
#(
    parameter int Q_DEPTH = SHA_Q_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                 s_tuser,   // [0] kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic                 m_tlast    // last
);

    logic   push_valid, push_ready;
    qitem_t push_item;
    logic   q_valid, q_pop;
    qitem_t q_item;

    sha_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    sha_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_item   (q_item)
    );

    sha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/sha_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks on the digest stream of the hasher.
// ----------------------------------------------------------------------------
module sha_checker
    import sha_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic [INDEX_W-1:0] out_idx;
    assign out_idx = m_tdata[DIGEST_W +: INDEX_W];

    // stalled digest word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("digest word changed while stalled");

    // tlast exactly on the eighth word
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (out_idx == DIGEST_LAST)))
        else $error("tlast does not match word index");

    // words of one digest come back to back in index order
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (out_idx == ($past(out_idx) + 3'd1)))
        else $error("digest words out of order");

    // a new digest needs at least one compression, never the next cycle
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("digest output right after last word");

    // an accepted input item carries defined kind and data
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !$isunknown({s_tuser, s_tdata}))
        else $error("input item undefined");

endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);
